[rtl/core/hxf_pkg.sv]
// Shared types and constants for the hex text codec formatter.
`default_nettype none

package hxf_pkg;

   localparam int LINE_CHARS_DEFAULT = 32;
   localparam int GROUP_CHARS        = 8;
   localparam int MAX_CHARS          = 5;
   localparam int COUNT_W            = $clog2(MAX_CHARS + 1);
   localparam int QUEUE_DEPTH        = 2;

   localparam logic [1:0] MODE_ENCODE   = 2'd0;
   localparam logic [1:0] MODE_DECODE   = 2'd1;
   localparam logic [1:0] MODE_BEAUTIFY = 2'd2;

   // All result characters caused by one accepted item.
   typedef struct packed {
      logic [MAX_CHARS-1:0][7:0] chars;
      logic [COUNT_W-1:0]        count;
   } desc_type;

endpackage

`default_nettype wire

[rtl/core/hxf_front.sv]
// Front end: accepts items, tracks layout and nibble state, builds result lists.
`default_nettype none

module hxf_front #(
   parameter int LINE_CHARS = hxf_pkg::LINE_CHARS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [1:0]       csr_wr_data,
   input  wire logic             push,
   input  wire logic [7:0]       req_in_byte,
   input  wire logic             req_end_of_stream,
   input  wire logic             q_full,
   output hxf_pkg::desc_type     q_data,
   output logic                  q_push
);

   localparam int PERIOD = LINE_CHARS * ((LINE_CHARS % 2) + 1);
   localparam int POS_W  = $clog2(PERIOD);
   localparam int GRP_W  = $clog2(hxf_pkg::GROUP_CHARS);

   localparam logic [1:0] SEP_NONE = 2'd0;
   localparam logic [1:0] SEP_ONE  = 2'd1;
   localparam logic [1:0] SEP_TWO  = 2'd2;
   localparam logic [1:0] SEP_NL   = 2'd3;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_NL    = 8'h0A;

   typedef struct packed {
      logic [hxf_pkg::MAX_CHARS-1:0][7:0] chars;
      logic [hxf_pkg::COUNT_W-1:0]        count;
      logic [POS_W-1:0]                   pos;
      logic [1:0]                         pend;
   } lay_type;

   logic [1:0]       mode_ff, mode_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [1:0]       pend_ff, pend_in;
   logic [3:0]       nib_ff, nib_in;
   logic             held_ff, held_in;

   logic             accept;
   logic [4:0]       hv;
   lay_type          s;

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      logic [7:0] c;
      if (n < 4'd10) c = 8'h30 + {4'd0, n};
      else           c = 8'h37 + {4'd0, n};
      return c;
   endfunction

   // Bit 4 set means the character is not a hex digit.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      if (c >= 8'h30 && c <= 8'h39)      v = {1'b0, 4'(c - 8'h30)};
      else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h37)};
      else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h57)};
      else                               v = 5'h10;
      return v;
   endfunction

   function automatic lay_type put(input lay_type a, input logic [7:0] c);
      lay_type r;
      r = a;
      if (r.count < hxf_pkg::COUNT_W'(hxf_pkg::MAX_CHARS)) begin
         r.chars[r.count] = c;
         r.count = r.count + 1'b1;
      end
      return r;
   endfunction

   // Emit the held separator, then the character, then pick the next separator.
   function automatic lay_type lay_out(input lay_type a, input logic [7:0] c);
      lay_type          r;
      logic [POS_W:0]   p1;
      r = a;
      case (r.pend)
         SEP_ONE: r = put(r, CH_SPACE);
         SEP_TWO: begin
            r = put(r, CH_SPACE);
            r = put(r, CH_SPACE);
         end
         SEP_NL:  r = put(r, CH_NL);
         default: ;
      endcase
      r = put(r, c);
      p1 = {1'b0, r.pos} + 1'b1;
      if (p1 >= (POS_W+1)'(PERIOD)) begin
         r.pos  = '0;
         r.pend = SEP_NL;
      end else begin
         r.pos = p1[POS_W-1:0];
         if (p1[GRP_W-1:0] == '0)  r.pend = SEP_TWO;
         else if (p1[0] == 1'b0)   r.pend = SEP_ONE;
         else                      r.pend = SEP_NONE;
      end
      return r;
   endfunction

   assign accept = push && !q_full;
   assign hv     = hex_value(req_in_byte);

   always_comb begin
      s        = '0;
      s.pos    = pos_ff;
      s.pend   = pend_ff;
      nib_in   = nib_ff;
      held_in  = held_ff;
      unique case (mode_ff)
         hxf_pkg::MODE_ENCODE: begin
            s = lay_out(s, hex_char(req_in_byte[7:4]));
            s = lay_out(s, hex_char(req_in_byte[3:0]));
         end
         hxf_pkg::MODE_DECODE: begin
            if (!hv[4]) begin
               if (held_ff) begin
                  s       = put(s, {nib_ff, hv[3:0]});
                  held_in = 1'b0;
                  nib_in  = '0;
               end else begin
                  nib_in  = hv[3:0];
                  held_in = 1'b1;
               end
            end
         end
         hxf_pkg::MODE_BEAUTIFY: begin
            if (!hv[4]) s = lay_out(s, req_in_byte);
         end
         default: ;
      endcase
      pos_in  = s.pos;
      pend_in = s.pend;
      if (req_end_of_stream) begin
         // Close the last line; the held separator is dropped.
         if ((mode_ff == hxf_pkg::MODE_ENCODE || mode_ff == hxf_pkg::MODE_BEAUTIFY) &&
             (s.pos != '0 || s.pend != SEP_NONE))
            s = put(s, CH_NL);
         pos_in  = '0;
         pend_in = SEP_NONE;
         nib_in  = '0;
         held_in = 1'b0;
      end
      mode_in = csr_wr_en ? csr_wr_data : mode_ff;
   end

   assign q_data.chars = s.chars;
   assign q_data.count = s.count;
   assign q_push       = accept && (s.count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= hxf_pkg::MODE_ENCODE;
         pos_ff  <= '0;
         pend_ff <= SEP_NONE;
         nib_ff  <= '0;
         held_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         if (accept) begin
            pos_ff  <= pos_in;
            pend_ff <= pend_in;
            nib_ff  <= nib_in;
            held_ff <= held_in;
         end
      end
   end

endmodule

`default_nettype wire

[rtl/core/hxf_queue.sv]
// Short queue of result lists between the front and back ends.
`default_nettype none

module hxf_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  hxf_pkg::desc_type     wr_data,
   output logic                  full,
   input  wire logic             rd_en,
   output hxf_pkg::desc_type     rd_data,
   output logic                  rd_valid
);

   localparam int PTR_W = $clog2(hxf_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(hxf_pkg::QUEUE_DEPTH + 1);

   hxf_pkg::desc_type slot_ff [hxf_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wp_ff, wp_in, rp_ff, rp_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              do_wr, do_rd;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(hxf_pkg::QUEUE_DEPTH - 1)) r = '0;
      else                                       r = p + 1'b1;
      return r;
   endfunction

   assign full     = (cnt_ff == CNT_W'(hxf_pkg::QUEUE_DEPTH));
   assign rd_valid = (cnt_ff != '0);
   assign rd_data  = slot_ff[rp_ff];
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && rd_valid;

   always_comb begin
      wp_in  = do_wr ? next_ptr(wp_ff) : wp_ff;
      rp_in  = do_rd ? next_ptr(rp_ff) : rp_ff;
      cnt_in = cnt_ff;
      if (do_wr && !do_rd)      cnt_in = cnt_ff + 1'b1;
      else if (!do_wr && do_rd) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_wr) slot_ff[wp_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/hxf_back.sv]
// Back end: walks each result list one character per cycle into the output register while it is empty or popped.
`default_nettype none

module hxf_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  hxf_pkg::desc_type     q_data,
   input  wire logic             q_valid,
   output logic                  q_pop,
   output logic                  empty,
   input  wire logic             pop,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_run_last
);

   logic                        valid_ff, valid_in;
   logic [7:0]                  byte_ff, byte_in;
   logic                        last_ff, last_in;
   logic [hxf_pkg::COUNT_W-1:0] idx_ff, idx_in;
   logic                        load, at_end;

   assign load   = q_valid && (!valid_ff || pop);
   assign at_end = (idx_ff == q_data.count - 1'b1);
   assign q_pop  = load && at_end;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = q_data.chars[idx_ff];
         last_in  = at_end;
         idx_in   = at_end ? '0 : idx_ff + 1'b1;
      end else if (pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign empty        = !valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_run_last = last_ff;

endmodule

`default_nettype wire

[rtl/core/hex_text_codec_formatter_core.sv]
// Hex text codec formatter: encode, decode or beautify a byte stream.
//
// Input channel: drive push with req_in_byte/req_end_of_stream; a transfer
// happens on a clock edge with push high and full low. Result channel: while
// empty is low, rsp_out_byte/rsp_run_last show the oldest result; pop takes it.
// rsp_run_last marks the last result of one input item. csr_wr_en writes the
// mode (0 encode, 1 decode, 2 beautify); write it only while the block is idle.
// An item's results enter the queue first, then the output register.
// Throughput: the output register moves one character per cycle while the
// receiver keeps taking results. An item yields 2 to 5 results in encode, 0 to
// 4 in beautify and 0 or 1 in decode; an item with no results is not queued. A
// two-entry queue between the front and back ends lets new items transfer while earlier results still drain.
// Reset (synchronous) selects encode mode, clears the line position, pending
// separator and held nibble, and empties the queue and output register.
// When the receiver stalls, the result holds; once the queue fills, full rises.
`default_nettype none

module hex_text_codec_formatter_core #(
   parameter int LINE_CHARS = hxf_pkg::LINE_CHARS_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic [1:0] csr_wr_data,
   input  wire logic       push,
   output logic            full,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_end_of_stream,
   output logic            empty,
   input  wire logic       pop,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_run_last
);

   hxf_pkg::desc_type wr_desc, rd_desc;
   logic              q_push, q_pop, q_valid;

   hxf_front #(.LINE_CHARS(LINE_CHARS)) u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .push              (push),
      .req_in_byte       (req_in_byte),
      .req_end_of_stream (req_end_of_stream),
      .q_full            (full),
      .q_data            (wr_desc),
      .q_push            (q_push)
   );

   hxf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_push),
      .wr_data  (wr_desc),
      .full     (full),
      .rd_en    (q_pop),
      .rd_data  (rd_desc),
      .rd_valid (q_valid)
   );

   hxf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_data       (rd_desc),
      .q_valid      (q_valid),
      .q_pop        (q_pop),
      .empty        (empty),
      .pop          (pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last)
   );

endmodule

`default_nettype wire

[rtl/core/hxf_checker.sv]
// Port-level assertions for the hex text codec formatter, bound to the top level.
`default_nettype none

module hxf_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       push,
   input wire logic       full,
   input wire logic       empty,
   input wire logic       pop,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_run_last
);

   // Reset leaves nothing to deliver and room to take items.
   a_reset_empty: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("block not idle after reset");

   // A stalled result holds its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_out_byte) && $stable(rsp_run_last))
      else $error("stalled result changed");

   // The rest of an item follows right after a non-last transfer.
   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      !empty && pop && !rsp_run_last |=> !empty)
      else $error("gap inside one item's results");

   // Nothing appears without an item having been taken in.
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      empty && $past(empty) && !$past(push) && !$past(push, 2) |=> empty)
      else $error("result without input");

endmodule

bind hex_text_codec_formatter_core hxf_checker u_hxf_checker (
   .clock        (clock),
   .reset        (reset),
   .push         (push),
   .full         (full),
   .empty        (empty),
   .pop          (pop),
   .rsp_out_byte (rsp_out_byte),
   .rsp_run_last (rsp_run_last)
);

`default_nettype wire
